>>> rtl/core/csds_pkg.sv
// Package for the clock source and divider selection block.
// Holds widths, constants, the reciprocal table and the microcode program.
// No dependencies.
package csds_pkg;

    // Table shape and fixed field widths
    localparam int NUM_SOURCES = 8;
    localparam int MAX_DIVIDER = 8;
    localparam int SRC_W       = 3;
    localparam int DIV_W       = 4;
    localparam int ENT_W       = 10;
    localparam int GRP_W       = 40;
    localparam int RATE_W      = 32;
    localparam int MHZ_W       = 13;   // rate / 1e6 of a 32-bit rate
    localparam int SCL_W       = 16;   // MHz times divisor, and ten times MHz
    localparam int NUM_W       = 19;   // ten times the excess of the scaled rate
    localparam int HZ_W        = 30;   // source rate in Hz
    localparam int ACC_W       = 35;   // rate times divider candidate
    localparam int CNT_W       = 5;
    localparam int OUT_W       = 64;
    localparam int CFG_W       = 64;
    localparam int ADDR_W      = 5;

    // Truncating divide by one million: (rate * MHZ_RECIP) >> MHZ_SHIFT
    localparam int             MHZ_SHIFT = 50;
    localparam int             MHZ_RC_W  = 31;
    localparam logic [MHZ_RC_W-1:0] MHZ_RECIP = 31'd1125899907;
    localparam logic [19:0]    HZ_PER_MHZ = 20'd1000000;

    // Truncating divide by a small divisor: (x * recip(d)) >> DQ_SHIFT, x < 2**NUM_W
    localparam int DQ_SHIFT = 22;
    localparam int RC_W     = 23;

    // Register map (index = paddr[4:3])
    localparam logic [1:0] REG_GROUP_A = 2'd0;
    localparam logic [1:0] REG_GROUP_B = 2'd1;
    localparam logic [1:0] REG_DEFAULT = 2'd2;

    localparam logic [GRP_W-1:0] GROUP_A_RST = 40'd263389044121;
    localparam logic [GRP_W-1:0] GROUP_B_RST = 40'd514850816;
    localparam logic [SRC_W-1:0] DEFAULT_RST = 3'd3;

    // Datapath operation of one microcode step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_MHZ_MUL,
        OP_INIT,
        OP_CAND_ERR,
        OP_CAND_CMP,
        OP_SRC_HZ,
        OP_CEIL,
        OP_QUO,
        OP_EMIT
    } t_op;

    // Sequencer condition of one microcode step
    typedef enum logic [2:0] {
        C_NEXT,
        C_GOTO,
        C_WAIT_IN,
        C_LOOP,
        C_WAIT_OUT
    } t_cond;

    localparam int PC_W = 4;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uop;

    // Program addresses
    localparam logic [PC_W-1:0] PC_WAIT     = 4'd0;
    localparam logic [PC_W-1:0] PC_MHZ_MUL  = 4'd1;
    localparam logic [PC_W-1:0] PC_INIT     = 4'd2;
    localparam logic [PC_W-1:0] PC_CAND_ERR = 4'd3;
    localparam logic [PC_W-1:0] PC_CAND_CMP = 4'd4;
    localparam logic [PC_W-1:0] PC_SRC_HZ   = 4'd5;
    localparam logic [PC_W-1:0] PC_CEIL     = 4'd6;
    localparam logic [PC_W-1:0] PC_QUO      = 4'd7;
    localparam logic [PC_W-1:0] PC_EMIT     = 4'd8;

    // Control store
    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            PC_WAIT:     u = '{op: OP_WAIT,     cond: C_WAIT_IN,  target: PC_WAIT};
            PC_MHZ_MUL:  u = '{op: OP_MHZ_MUL,  cond: C_NEXT,     target: PC_WAIT};
            PC_INIT:     u = '{op: OP_INIT,     cond: C_NEXT,     target: PC_WAIT};
            PC_CAND_ERR: u = '{op: OP_CAND_ERR, cond: C_NEXT,     target: PC_WAIT};
            PC_CAND_CMP: u = '{op: OP_CAND_CMP, cond: C_LOOP,     target: PC_CAND_ERR};
            PC_SRC_HZ:   u = '{op: OP_SRC_HZ,   cond: C_NEXT,     target: PC_WAIT};
            PC_CEIL:     u = '{op: OP_CEIL,     cond: C_LOOP,     target: PC_CEIL};
            PC_QUO:      u = '{op: OP_QUO,      cond: C_LOOP,     target: PC_QUO};
            PC_EMIT:     u = '{op: OP_EMIT,     cond: C_WAIT_OUT, target: PC_WAIT};
            default:     u = '{op: OP_NOP,      cond: C_GOTO,     target: PC_WAIT};
        endcase
        return u;
    endfunction

    // ceil(2**DQ_SHIFT / d) for d in 1..8
    function automatic logic [RC_W-1:0] recip(input logic [DIV_W-1:0] d);
        logic [RC_W-1:0] r;
        case (d)
            4'd1:    r = 23'd4194304;
            4'd2:    r = 23'd2097152;
            4'd3:    r = 23'd1398102;
            4'd4:    r = 23'd1048576;
            4'd5:    r = 23'd838861;
            4'd6:    r = 23'd699051;
            4'd7:    r = 23'd599187;
            4'd8:    r = 23'd524288;
            default: r = 23'd4194304;
        endcase
        return r;
    endfunction

    // Source frequency in MHz from the two packed groups
    function automatic logic [ENT_W-1:0] source_entry(
        input logic [GRP_W-1:0] grp_a,
        input logic [GRP_W-1:0] grp_b,
        input logic [SRC_W-1:0] idx
    );
        logic [GRP_W-1:0] grp;
        grp = idx[2] ? grp_b : grp_a;
        return grp[idx[1:0]*ENT_W +: ENT_W];
    endfunction

endpackage

>>> rtl/core/clock_source_divider_select.sv
// Clock source and divider selection, microcoded sequencer over a small datapath.
// Depends on csds_pkg (constants, reciprocal table, control store).
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  s stream | in  | i_s_tvalid/o_s_tready  | i_s_tdata: target_rate_hz
//  m stream | out | o_m_tvalid/i_m_tready  | o_m_tdata: select, divider, MHz, rate, ...
//  config   | in  | psel/penable/pwrite    | paddr, pwdata, prdata (64-bit registers)
//
// One item is worked at a time, from acceptance to the result register, through the
// candidate loop (two steps per source/divisor pair, up to 64 pairs), the ceiling
// search (up to 8 steps) and the bit-serial quotient (30 steps); the next item is
// accepted only after the result is loaded.
// Reset is synchronous, active low; control and config registers get reset values.
// A held result stalls the sequencer only in its final step.
module clock_source_divider_select
    import csds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [31:0]       i_s_tdata,   // [31:0] target_rate_hz
    // Output stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // [2:0] source_select, [6:3] divider, [16:7] source_mhz,
    // [46:17] achieved_rate_hz, [47] second_pll_used, [60:48] control_field, [63:61] 0
    output logic [OUT_W-1:0]  o_m_tdata,
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    // Sequencer and configuration state
    logic [PC_W-1:0]  r_pc, n_pc;
    logic [GRP_W-1:0] r_grp_a, r_grp_b;
    logic [SRC_W-1:0] r_default;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    // Datapath registers
    logic [RATE_W-1:0]          r_rate;
    logic [RATE_W+MHZ_RC_W-1:0] r_prod;
    logic [MHZ_W-1:0]           r_mhz;
    logic [SCL_W-1:0]           r_best_err;
    logic [SRC_W-1:0]           r_best;
    logic [SCL_W-1:0]           r_scaled;
    logic [DIV_W-1:0]           r_dv;
    logic [SRC_W-1:0]           r_sx;
    logic                       r_ok;
    logic [NUM_W-1:0]           r_num;
    logic [ENT_W-1:0]           r_src_mhz;
    logic [HZ_W-1:0]            r_src_hz;
    logic [DIV_W-1:0]           r_k;
    logic [ACC_W-1:0]           r_acc;
    logic [HZ_W-1:0]            r_quo;
    logic [DIV_W-1:0]           r_rem;
    logic [CNT_W-1:0]           r_cnt;

    t_uop w_uop;
    logic w_in_acc, w_out_free, w_more, w_cfg_wr;

    assign w_uop      = ucode(r_pc);
    assign o_s_tready = i_rst_n && (w_uop.op == OP_WAIT);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    // Register read
    always_comb begin
        case (paddr[4:3])
            REG_GROUP_A: prdata = {{(CFG_W-GRP_W){1'b0}}, r_grp_a};
            REG_GROUP_B: prdata = {{(CFG_W-GRP_W){1'b0}}, r_grp_b};
            REG_DEFAULT: prdata = {{(CFG_W-SRC_W){1'b0}}, r_default};
            default:     prdata = '0;
        endcase
    end

    // Candidate error: ten times the excess of the scaled rate over the source
    logic [ENT_W-1:0] w_src;
    logic [SCL_W-1:0] w_diff;
    logic             w_ok;
    logic [NUM_W-1:0] w_num;

    assign w_src  = source_entry(r_grp_a, r_grp_b, r_sx);
    assign w_ok   = (w_src != '0) && ({{(SCL_W-ENT_W){1'b0}}, w_src} <= r_scaled);
    assign w_diff = r_scaled - {{(SCL_W-ENT_W){1'b0}}, w_src};
    assign w_num  = ({{(NUM_W-SCL_W){1'b0}}, w_diff} << 3)
                  + ({{(NUM_W-SCL_W){1'b0}}, w_diff} << 1);

    // Candidate compare: error divided by the divisor through its reciprocal
    logic [NUM_W+RC_W-1:0] w_qprod;
    logic [NUM_W-1:0]      w_q;
    logic                  w_win, w_zero, w_last;

    assign w_qprod = {{RC_W{1'b0}}, r_num} * {{NUM_W{1'b0}}, recip(r_dv)};
    assign w_q     = w_qprod[DQ_SHIFT +: NUM_W];
    assign w_win   = r_ok && (w_q < {{(NUM_W-SCL_W){1'b0}}, r_best_err});
    assign w_zero  = w_win && (w_q == '0);
    assign w_last  = (r_sx == SRC_W'(NUM_SOURCES-1)) && (r_dv == DIV_W'(MAX_DIVIDER));

    // Initial MHz value and selected source
    logic [MHZ_W-1:0] w_mhz;
    logic [ENT_W-1:0] w_sel_mhz;
    logic [HZ_W-1:0]  w_sel_hz;

    assign w_mhz     = r_prod[MHZ_SHIFT +: MHZ_W];
    assign w_sel_mhz = source_entry(r_grp_a, r_grp_b, r_best);
    assign w_sel_hz  = HZ_W'(w_sel_mhz) * HZ_W'(HZ_PER_MHZ);

    // Ceiling search and quotient bit
    logic             w_acc_ge, w_ceil_more;
    logic [DIV_W:0]   w_t;
    logic             w_ge;

    assign w_acc_ge    = r_acc >= {{(ACC_W-HZ_W){1'b0}}, r_src_hz};
    assign w_ceil_more = (r_rate != '0) && !w_acc_ge && (r_k != DIV_W'(MAX_DIVIDER));
    assign w_t         = {r_rem, r_quo[HZ_W-1]};
    assign w_ge        = w_t >= {1'b0, r_k};

    // Loop condition of the current step
    always_comb begin
        case (w_uop.op)
            OP_CAND_CMP: w_more = !w_zero && !w_last;
            OP_CEIL:     w_more = w_ceil_more;
            OP_QUO:      w_more = (r_cnt != CNT_W'(HZ_W-1));
            default:     w_more = 1'b0;
        endcase
    end

    // Next step address
    always_comb begin
        case (w_uop.cond)
            C_NEXT:     n_pc = r_pc + 1'b1;
            C_GOTO:     n_pc = w_uop.target;
            C_WAIT_IN:  n_pc = w_in_acc ? r_pc + 1'b1 : r_pc;
            C_LOOP:     n_pc = w_more ? w_uop.target : r_pc + 1'b1;
            C_WAIT_OUT: n_pc = w_out_free ? w_uop.target : r_pc;
            default:    n_pc = PC_WAIT;
        endcase
    end

    // Control state: step counter, result flag, registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_WAIT;
            r_out_valid <= 1'b0;
            r_grp_a     <= GROUP_A_RST;
            r_grp_b     <= GROUP_B_RST;
            r_default   <= DEFAULT_RST;
        end else begin
            r_pc <= n_pc;
            if (w_uop.op == OP_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                case (paddr[4:3])
                    REG_GROUP_A: r_grp_a   <= pwdata[GRP_W-1:0];
                    REG_GROUP_B: r_grp_b   <= pwdata[GRP_W-1:0];
                    REG_DEFAULT: r_default <= pwdata[SRC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath: one operation per control word
    always_ff @(posedge i_clk) begin
        case (w_uop.op)
            OP_WAIT: begin
                if (w_in_acc) begin
                    r_rate <= i_s_tdata;
                end
            end
            OP_MHZ_MUL: begin
                r_prod <= {{MHZ_RC_W{1'b0}}, r_rate} * {{RATE_W{1'b0}}, MHZ_RECIP};
            end
            OP_INIT: begin
                r_mhz      <= w_mhz;
                r_best_err <= ({{(SCL_W-MHZ_W){1'b0}}, w_mhz} << 3)
                            + ({{(SCL_W-MHZ_W){1'b0}}, w_mhz} << 1);
                r_best     <= r_default;
                r_scaled   <= {{(SCL_W-MHZ_W){1'b0}}, w_mhz};
                r_dv       <= DIV_W'(1);
                r_sx       <= '0;
            end
            OP_CAND_ERR: begin
                r_ok  <= w_ok;
                r_num <= w_num;
            end
            OP_CAND_CMP: begin
                // Keep the first strictly better candidate
                if (w_win) begin
                    r_best_err <= w_q[SCL_W-1:0];
                    r_best     <= r_sx;
                end
                // Advance source, then divisor
                if (r_sx == SRC_W'(NUM_SOURCES-1)) begin
                    r_sx     <= '0;
                    r_dv     <= r_dv + 1'b1;
                    r_scaled <= r_scaled + {{(SCL_W-MHZ_W){1'b0}}, r_mhz};
                end else begin
                    r_sx <= r_sx + 1'b1;
                end
            end
            OP_SRC_HZ: begin
                r_src_mhz <= w_sel_mhz;
                r_src_hz  <= w_sel_hz;
                r_quo     <= w_sel_hz;
                r_k       <= DIV_W'(1);
                r_acc     <= {{(ACC_W-RATE_W){1'b0}}, r_rate};
                r_rem     <= '0;
                r_cnt     <= '0;
            end
            OP_CEIL: begin
                // Smallest divider, at most 8, whose rate multiple covers the source
                if (r_rate == '0) begin
                    r_k <= DIV_W'(MAX_DIVIDER);
                end else if (w_ceil_more) begin
                    r_k   <= r_k + 1'b1;
                    r_acc <= r_acc + {{(ACC_W-RATE_W){1'b0}}, r_rate};
                end
            end
            OP_QUO: begin
                // Restoring division, one quotient bit a step
                r_rem <= w_ge ? DIV_W'(w_t - {1'b0, r_k}) : w_t[DIV_W-1:0];
                r_quo <= {r_quo[HZ_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            OP_EMIT: begin
                if (w_out_free) begin
                    r_out_data <= {3'b000,
                                   1'b1, 3'(r_k - 1'b1), r_best, 6'b000000,
                                   (r_best == SRC_W'(1)),
                                   r_quo, r_src_mhz, r_k, r_best};
                end
            end
            default: ;
        endcase
    end

    // Checks
    a_emit_to_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_EMIT && w_out_free) |=> (r_pc == PC_WAIT && o_m_tvalid))
        else $error("result not loaded after final step");

    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[6:3] != 4'd0 && o_m_tdata[6:3] <= DIV_W'(MAX_DIVIDER)))
        else $error("divider out of range");

    a_ctrl_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[59:57] == 3'(o_m_tdata[6:3] - 1'b1)
                        && o_m_tdata[56:54] == o_m_tdata[2:0] && o_m_tdata[60]))
        else $error("control field disagrees with selection");

    a_divisor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_CAND_ERR) |-> (r_dv != 4'd0 && r_dv <= DIV_W'(MAX_DIVIDER)))
        else $error("search divisor out of range");

endmodule
